FILE: rtl/flm_pkg.sv
package flm_pkg;

    localparam int COORD_WIDTH_DEF = 16;
    localparam int LINE_W          = 18;   // signed width of model line coordinates
    localparam int CFG_W           = 15;
    localparam int CFG_IDX_W       = 3;
    localparam int TGT_W           = 4;
    localparam int MEAN_W          = 16;
    localparam int LEN_W           = 32;
    localparam int CNT_W           = 4;
    localparam int NUM_TGT         = 12;
    localparam int MEAN_ROUND      = 3;
    localparam int MEAN_DIV        = 6;

    // divide by six as a reciprocal multiply, exact below the saturation point
    localparam int          MEAN_XW    = 19;
    localparam int          MEAN_RW    = 20;
    localparam int          MEAN_SHIFT = 22;
    localparam logic [19:0] MEAN_RECIP = 20'd699051;   // ceil(2^22 / 6)
    localparam int          MEAN_SAT   = 393216;       // 6 * 65536

    localparam logic [TGT_W-1:0] TGT_FIRST  = 4'd0;
    localparam logic [TGT_W-1:0] LAST_LINE  = 4'd10;
    localparam logic [TGT_W-1:0] TGT_CIRCLE = 4'd11;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_FIELD_LEN = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FIELD_WID = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_GOAL_DEP  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_GOAL_WID  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_CIRC_DIA  = 3'd4;

    localparam logic [CFG_W-1:0] RST_FIELD_LEN = 15'd9216;
    localparam logic [CFG_W-1:0] RST_FIELD_WID = 15'd6144;
    localparam logic [CFG_W-1:0] RST_GOAL_DEP  = 15'd1024;
    localparam logic [CFG_W-1:0] RST_GOAL_WID  = 15'd5120;
    localparam logic [CFG_W-1:0] RST_CIRC_DIA  = 15'd1536;

    // arithmetic unit modes
    localparam logic [1:0] MODE_MUL  = 2'd0;
    localparam logic [1:0] MODE_SQRT = 2'd1;
    localparam logic [1:0] MODE_DIV  = 2'd2;

    // operand selection
    localparam logic [2:0] OPS_SQX    = 3'd0;
    localparam logic [2:0] OPS_SQY    = 3'd1;
    localparam logic [2:0] OPS_ROOT   = 3'd2;
    localparam logic [2:0] OPS_CMUL_X = 3'd3;
    localparam logic [2:0] OPS_CMUL_Y = 3'd4;
    localparam logic [2:0] OPS_CDIV   = 3'd5;

    // one-cycle datapath actions
    localparam logic [3:0] ACT_NONE    = 4'd0;
    localparam logic [3:0] ACT_LOAD    = 4'd1;
    localparam logic [3:0] ACT_ACCL    = 4'd2;
    localparam logic [3:0] ACT_ACCC    = 4'd3;
    localparam logic [3:0] ACT_CMP     = 4'd4;
    localparam logic [3:0] ACT_NSAVE   = 4'd5;
    localparam logic [3:0] ACT_PLINE   = 4'd6;
    localparam logic [3:0] ACT_PCZERO  = 4'd7;
    localparam logic [3:0] ACT_PCX     = 4'd8;
    localparam logic [3:0] ACT_PCY     = 4'd9;
    localparam logic [3:0] ACT_LEN     = 4'd10;
    localparam logic [3:0] ACT_PUBLISH = 4'd11;

    // phases: pick the point pair whose distance is taken
    localparam logic [2:0] PH_LINE = 3'd0;
    localparam logic [2:0] PH_SEG  = 3'd1;
    localparam logic [2:0] PH_CIRC = 3'd2;
    localparam logic [2:0] PH_CPN  = 3'd3;
    localparam logic [2:0] PH_LEN  = 3'd4;

    typedef struct packed {
        logic             start;
        logic [1:0]       mode;
        logic [2:0]       opsel;
        logic [2:0]       ph;
        logic [1:0]       pt;
        logic [TGT_W-1:0] tgt;
        logic [3:0]       act;
    } cmd_t;

    typedef struct packed {
        logic unit_done;
        logic root_lt_r;
        logic root_zero;
        logic tgt_circ;
    } status_t;

endpackage

FILE: rtl/flm_arith.sv
module flm_arith #(
    parameter int OPW  = 40,
    parameter int MULN = 19
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           start,
    input  logic [1:0]     mode,
    input  logic [OPW-1:0] opa,
    input  logic [OPW-1:0] opb,
    input  logic [OPW-1:0] opc,
    output logic           done,
    output logic [OPW-1:0] result
);
    import flm_pkg::*;

    localparam int CW = $clog2(OPW + 1);

    logic           busy_reg, busy_next;
    logic           done_reg, done_next;
    logic [1:0]     mode_reg, mode_next;
    logic [CW-1:0]  cnt_reg, cnt_next;
    logic [OPW-1:0] a_reg, a_next;
    logic [OPW-1:0] b_reg, b_next;
    logic [OPW:0]   acc_reg, acc_next;
    logic [CW-1:0]  last;
    logic [OPW:0]   trial;
    logic [OPW:0]   remsh;

    always_comb
    begin
        unique case (mode_reg)
            MODE_MUL:  last = CW'(MULN - 1);
            MODE_SQRT: last = CW'(OPW / 2 - 1);
            MODE_DIV:  last = CW'(OPW - 1);
            default:   last = '0;
        endcase
    end

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        mode_next = mode_reg;
        cnt_next  = cnt_reg;
        a_next    = a_reg;
        b_next    = b_reg;
        acc_next  = acc_reg;
        trial     = {1'b0, a_reg} + {1'b0, b_reg};
        remsh     = {acc_reg[OPW-1:0], a_reg[OPW-1]};
        if (start)
        begin
            busy_next = 1'b1;
            mode_next = mode;
            cnt_next  = '0;
            unique case (mode)
                MODE_SQRT:
                begin
                    acc_next = {1'b0, opa};
                    a_next   = '0;
                    b_next   = {2'b01, {(OPW-2){1'b0}}};
                end
                MODE_DIV:
                begin
                    a_next   = opa;
                    b_next   = opb;
                    acc_next = '0;
                end
                default:
                begin
                    a_next   = opa;
                    b_next   = opb;
                    acc_next = {1'b0, opc};
                end
            endcase
        end
        else if (busy_reg)
        begin
            unique case (mode_reg)
                MODE_SQRT:
                begin
                    if (acc_reg >= trial)
                    begin
                        acc_next = acc_reg - trial;
                        a_next   = (a_reg >> 1) + b_reg;
                    end
                    else
                    begin
                        a_next = a_reg >> 1;
                    end
                    b_next = b_reg >> 2;
                end
                MODE_DIV:
                begin
                    if (remsh >= {1'b0, b_reg})
                    begin
                        acc_next = remsh - {1'b0, b_reg};
                        a_next   = {a_reg[OPW-2:0], 1'b1};
                    end
                    else
                    begin
                        acc_next = remsh;
                        a_next   = {a_reg[OPW-2:0], 1'b0};
                    end
                end
                default:
                begin
                    // shift-add multiply, one multiplier bit a cycle
                    if (b_reg[0])
                        acc_next = acc_reg + {1'b0, a_reg};
                    a_next = a_reg << 1;
                    b_next = b_reg >> 1;
                end
            endcase
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == last)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            mode_reg <= MODE_MUL;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            mode_reg <= mode_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        a_reg   <= a_next;
        b_reg   <= b_next;
        acc_reg <= acc_next;
    end

    assign done   = done_reg;
    assign result = (mode_reg == MODE_MUL) ? acc_reg[OPW-1:0] : a_reg;

endmodule

FILE: rtl/flm_datapath.sv
module flm_datapath #(
    parameter int COORD_WIDTH = 16
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   cfg_we,
    input  logic [flm_pkg::CFG_IDX_W-1:0]          cfg_index,
    input  logic [flm_pkg::CFG_W-1:0]              cfg_data,
    input  logic signed [COORD_WIDTH-1:0]          seg_start_x,
    input  logic signed [COORD_WIDTH-1:0]          seg_start_y,
    input  logic signed [COORD_WIDTH-1:0]          seg_end_x,
    input  logic signed [COORD_WIDTH-1:0]          seg_end_y,
    input  logic                                   frame_start,
    input  flm_pkg::cmd_t                          cmd,
    output flm_pkg::status_t                       st,
    output logic [flm_pkg::TGT_W-1:0]              matched_target,
    output logic [flm_pkg::MEAN_W-1:0]             mean_distance,
    output logic signed [COORD_WIDTH-1:0]          mid_proj_x,
    output logic signed [COORD_WIDTH-1:0]          mid_proj_y,
    output logic signed [COORD_WIDTH-1:0]          start_proj_x,
    output logic signed [COORD_WIDTH-1:0]          start_proj_y,
    output logic signed [COORD_WIDTH-1:0]          end_proj_x,
    output logic signed [COORD_WIDTH-1:0]          end_proj_y,
    output logic [flm_pkg::LEN_W-1:0]              length_total,
    output logic [flm_pkg::CNT_W-1:0]              distinct_count
);
    import flm_pkg::*;

    localparam int PW  = (COORD_WIDTH + 1 > LINE_W) ? COORD_WIDTH + 1 : LINE_W;
    localparam int DW  = PW + 1;
    localparam int OPW = 2 * DW + 2;
    localparam int RW  = DW + 1;
    localparam int SW  = RW + 2;
    localparam int AW  = ((RW > LEN_W) ? RW : LEN_W) + 1;
    localparam int MPW = MEAN_XW + MEAN_RW;

    typedef struct packed {
        logic signed [LINE_W-1:0] xlo;
        logic signed [LINE_W-1:0] xhi;
        logic signed [LINE_W-1:0] ylo;
        logic signed [LINE_W-1:0] yhi;
    } box_t;

    function automatic box_t line_box(input logic [TGT_W-1:0] t, input logic [CFG_W-1:0] a,
                                      input logic [CFG_W-1:0] b, input logic [CFG_W-1:0] e,
                                      input logic [CFG_W-1:0] f);
        logic signed [LINE_W-1:0] sa, sb, se2, sf, il, ol;
        box_t bx;
        sa  = $signed({{(LINE_W-CFG_W){1'b0}}, a});
        sb  = $signed({{(LINE_W-CFG_W){1'b0}}, b});
        sf  = $signed({{(LINE_W-CFG_W){1'b0}}, f});
        se2 = $signed({{(LINE_W-CFG_W-1){1'b0}}, e, 1'b0});
        il  = se2 - sa;   // inner goal line, left
        ol  = sa - se2;   // inner goal line, right
        bx  = '0;
        case (t)
            4'd0:    bx = '{-sa, sa, -sb, -sb};
            4'd1:    bx = '{-sa, sa, sb, sb};
            4'd2:    bx = '{-sa, il, -sf, -sf};
            4'd3:    bx = '{-sa, il, sf, sf};
            4'd4:    bx = '{ol, sa, -sf, -sf};
            4'd5:    bx = '{ol, sa, sf, sf};
            4'd6:    bx = '{-sa, -sa, -sb, sb};
            4'd7:    bx = '{'0, '0, -sb, sb};
            4'd8:    bx = '{sa, sa, -sb, sb};
            4'd9:    bx = '{il, il, -sf, sf};
            4'd10:   bx = '{ol, ol, -sf, sf};
            default: bx = '0;
        endcase
        return bx;
    endfunction

    function automatic logic signed [PW-1:0] clamp(input logic signed [PW-1:0] p,
                                                   input logic signed [LINE_W-1:0] lo,
                                                   input logic signed [LINE_W-1:0] hi);
        logic signed [PW-1:0] l, h;
        l = PW'(lo);
        h = PW'(hi);
        if (p < l)
            return l;
        else if (p > h)
            return h;
        return p;
    endfunction

    function automatic logic [PW-1:0] mag_p(input logic signed [PW-1:0] p);
        return p[PW-1] ? PW'(-p) : PW'(p);
    endfunction

    function automatic logic [DW-1:0] mag_d(input logic signed [PW-1:0] p,
                                            input logic signed [PW-1:0] q);
        logic signed [DW-1:0] d;
        d = DW'(p) - DW'(q);
        return d[DW-1] ? DW'(-d) : DW'(d);
    endfunction

    function automatic logic signed [COORD_WIDTH-1:0] out_coord(input logic signed [PW-1:0] v);
        logic signed [PW:0] t;
        t = (PW+1)'(v) + (PW+1)'(1);
        t = t >>> 1;
        return t[COORD_WIDTH-1:0];
    endfunction

    logic [CFG_W-1:0]        flen_reg, fwid_reg, gdep_reg, gwid_reg, dia_reg;
    logic signed [PW-1:0]    px_reg [3];
    logic signed [PW-1:0]    py_reg [3];
    logic signed [PW-1:0]    qx_reg [3];
    logic signed [PW-1:0]    qy_reg [3];
    logic [SW-1:0]           sum_reg, best_reg;
    logic [TGT_W-1:0]        tgt_reg;
    logic [RW-1:0]           n_reg;
    logic [LEN_W-1:0]        accum_reg;
    logic [NUM_TGT-1:0]      seen_reg;

    logic [TGT_W-1:0]        o_tgt_reg;
    logic [MEAN_W-1:0]       o_mean_reg;
    logic signed [COORD_WIDTH-1:0] o_mx_reg, o_my_reg, o_sx_reg, o_sy_reg, o_ex_reg, o_ey_reg;
    logic [LEN_W-1:0]        o_len_reg;
    logic [CNT_W-1:0]        o_cnt_reg;

    logic signed [PW-1:0]    sx_e, sy_e, ex_e, ey_e;
    box_t                    scan_box, win_box;
    logic signed [PW-1:0]    ax, ay, bx, by;
    logic [DW-1:0]           mdx, mdy;
    logic [OPW-1:0]          opa, opb, opc, u_result;
    logic                    u_done;
    logic [RW-1:0]           root;
    logic [RW-1:0]           rad;
    logic [RW-1:0]           rdiff;
    logic [PW-1:0]           quot;
    logic [RW:0]             lenv;
    logic [AW-1:0]           acc_sum;
    logic [CNT_W-1:0]        pop;
    logic [NUM_TGT-1:0]      seen_new;
    logic [SW:0]             mean_x;
    logic [MPW-1:0]          mean_prod;
    logic [MEAN_W-1:0]       mean_val;

    assign sx_e = seg_start_x;
    assign sy_e = seg_start_y;
    assign ex_e = seg_end_x;
    assign ey_e = seg_end_y;

    assign scan_box = line_box(cmd.tgt, flen_reg, fwid_reg, gdep_reg, gwid_reg);
    assign win_box  = line_box(tgt_reg, flen_reg, fwid_reg, gdep_reg, gwid_reg);

    // point pair whose distance goes to the unit
    always_comb
    begin
        ax = px_reg[cmd.pt];
        ay = py_reg[cmd.pt];
        bx = '0;
        by = '0;
        case (cmd.ph)
            PH_LINE:
            begin
                bx = clamp(px_reg[cmd.pt], scan_box.xlo, scan_box.xhi);
                by = clamp(py_reg[cmd.pt], scan_box.ylo, scan_box.yhi);
            end
            PH_SEG:
            begin
                ax = px_reg[1];
                ay = py_reg[1];
                bx = px_reg[2];
                by = py_reg[2];
            end
            PH_LEN:
            begin
                ax = qx_reg[1];
                ay = qy_reg[1];
                bx = qx_reg[2];
                by = qy_reg[2];
            end
            default:
            begin
                bx = '0;
                by = '0;
            end
        endcase
    end

    assign mdx = mag_d(ax, bx);
    assign mdy = mag_d(ay, by);

    always_comb
    begin
        opa = '0;
        opb = '0;
        opc = '0;
        unique case (cmd.opsel)
            OPS_SQX:
            begin
                opa = OPW'(mdx);
                opb = OPW'(mdx);
            end
            OPS_SQY:
            begin
                opa = OPW'(mdy);
                opb = OPW'(mdy);
                opc = u_result;
            end
            OPS_ROOT:
                opa = u_result;
            OPS_CMUL_X:
            begin
                opa = OPW'(mag_p(px_reg[cmd.pt]));
                opb = OPW'({dia_reg, 1'b0});
                opc = OPW'(n_reg);
            end
            OPS_CMUL_Y:
            begin
                opa = OPW'(mag_p(py_reg[cmd.pt]));
                opb = OPW'({dia_reg, 1'b0});
                opc = OPW'(n_reg);
            end
            OPS_CDIV:
            begin
                opa = u_result;
                opb = OPW'({n_reg, 1'b0});
            end
            default:
                opa = '0;
        endcase
    end

    flm_arith #(
        .OPW  (OPW),
        .MULN (DW)
    ) u_arith (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (cmd.start),
        .mode   (cmd.mode),
        .opa    (opa),
        .opb    (opb),
        .opc    (opc),
        .done   (u_done),
        .result (u_result)
    );

    assign root  = u_result[RW-1:0];
    assign rad   = RW'(dia_reg);
    assign rdiff = (root >= rad) ? root - rad : rad - root;
    assign quot  = u_result[PW-1:0];
    assign lenv  = ((RW+1)'(root) + 1'b1) >> 1;
    assign acc_sum = AW'(accum_reg) + AW'(lenv);
    assign seen_new = seen_reg | (NUM_TGT'(1) << tgt_reg);

    // rounded mean of the three distances, saturated
    assign mean_x    = (SW+1)'(best_reg) + (SW+1)'(MEAN_ROUND);
    assign mean_prod = MPW'(mean_x[MEAN_XW-1:0]) * MPW'(MEAN_RECIP);
    assign mean_val  = (mean_x >= (SW+1)'(MEAN_SAT)) ? '1 : mean_prod[MEAN_SHIFT +: MEAN_W];

    always_comb
    begin
        pop = '0;
        for (int i = 0; i < NUM_TGT; i++)
            pop = pop + CNT_W'(seen_reg[i]);
    end

    assign st.unit_done = u_done;
    assign st.root_lt_r = (u_result < OPW'(dia_reg));
    assign st.root_zero = (u_result == '0);
    assign st.tgt_circ  = (tgt_reg == TGT_CIRCLE);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            flen_reg  <= RST_FIELD_LEN;
            fwid_reg  <= RST_FIELD_WID;
            gdep_reg  <= RST_GOAL_DEP;
            gwid_reg  <= RST_GOAL_WID;
            dia_reg   <= RST_CIRC_DIA;
            accum_reg <= '0;
            seen_reg  <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                unique case (cfg_index)
                    CFG_FIELD_LEN: flen_reg <= cfg_data;
                    CFG_FIELD_WID: fwid_reg <= cfg_data;
                    CFG_GOAL_DEP:  gdep_reg <= cfg_data;
                    CFG_GOAL_WID:  gwid_reg <= cfg_data;
                    CFG_CIRC_DIA:  dia_reg  <= cfg_data;
                    default:       ;
                endcase
            end
            if (cmd.act == ACT_LOAD && frame_start)
            begin
                accum_reg <= '0;
                seen_reg  <= '0;
            end
            if (cmd.act == ACT_LEN)
            begin
                // saturating running length
                if (acc_sum > AW'({LEN_W{1'b1}}))
                    accum_reg <= '1;
                else
                    accum_reg <= acc_sum[LEN_W-1:0];
                seen_reg <= seen_new;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        case (cmd.act)
            ACT_LOAD:
            begin
                px_reg[0] <= sx_e + ex_e;
                py_reg[0] <= sy_e + ey_e;
                px_reg[1] <= sx_e <<< 1;
                py_reg[1] <= sy_e <<< 1;
                px_reg[2] <= ex_e <<< 1;
                py_reg[2] <= ey_e <<< 1;
                sum_reg   <= '0;
            end
            ACT_ACCL:
                sum_reg <= sum_reg + SW'(root);
            ACT_ACCC:
                sum_reg <= sum_reg + SW'(rdiff);
            ACT_CMP:
            begin
                // strict minimum keeps the earlier target on a tie
                if (cmd.tgt == TGT_FIRST || sum_reg < best_reg)
                begin
                    best_reg <= sum_reg;
                    tgt_reg  <= cmd.tgt;
                end
                sum_reg <= '0;
            end
            ACT_NSAVE:
                n_reg <= root;
            ACT_PLINE:
            begin
                qx_reg[cmd.pt] <= clamp(px_reg[cmd.pt], win_box.xlo, win_box.xhi);
                qy_reg[cmd.pt] <= clamp(py_reg[cmd.pt], win_box.ylo, win_box.yhi);
            end
            ACT_PCZERO:
            begin
                qx_reg[cmd.pt] <= PW'(dia_reg);
                qy_reg[cmd.pt] <= '0;
            end
            ACT_PCX:
                qx_reg[cmd.pt] <= px_reg[cmd.pt][PW-1] ? -$signed(quot) : $signed(quot);
            ACT_PCY:
                qy_reg[cmd.pt] <= py_reg[cmd.pt][PW-1] ? -$signed(quot) : $signed(quot);
            ACT_PUBLISH:
            begin
                o_tgt_reg  <= tgt_reg;
                o_mean_reg <= mean_val;
                o_mx_reg   <= out_coord(qx_reg[0]);
                o_my_reg   <= out_coord(qy_reg[0]);
                o_sx_reg   <= out_coord(qx_reg[1]);
                o_sy_reg   <= out_coord(qy_reg[1]);
                o_ex_reg   <= out_coord(qx_reg[2]);
                o_ey_reg   <= out_coord(qy_reg[2]);
                o_len_reg  <= accum_reg;
                o_cnt_reg  <= pop;
            end
            default:
                ;
        endcase
    end

    assign matched_target = o_tgt_reg;
    assign mean_distance  = o_mean_reg;
    assign mid_proj_x     = o_mx_reg;
    assign mid_proj_y     = o_my_reg;
    assign start_proj_x   = o_sx_reg;
    assign start_proj_y   = o_sy_reg;
    assign end_proj_x     = o_ex_reg;
    assign end_proj_y     = o_ey_reg;
    assign length_total   = o_len_reg;
    assign distinct_count = o_cnt_reg;

endmodule

FILE: rtl/flm_ctrl.sv
module flm_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    output logic              out_valid,
    input  logic              out_ready,
    input  flm_pkg::status_t  st,
    output flm_pkg::cmd_t     cmd
);
    import flm_pkg::*;

    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_SQX  = 4'd1;
    localparam logic [3:0] S_SQY  = 4'd2;
    localparam logic [3:0] S_RT   = 4'd3;
    localparam logic [3:0] S_CMP  = 4'd4;
    localparam logic [3:0] S_PROJ = 4'd5;
    localparam logic [3:0] S_CMX  = 4'd6;
    localparam logic [3:0] S_CDX  = 4'd7;
    localparam logic [3:0] S_CMY  = 4'd8;
    localparam logic [3:0] S_CDY  = 4'd9;
    localparam logic [3:0] S_OUT  = 4'd11;

    logic [3:0]       state_reg, state_next;
    logic             go_reg, go_next;
    logic [2:0]       ph_reg, ph_next;
    logic [TGT_W-1:0] j_reg, j_next;
    logic [1:0]       k_reg, k_next;
    logic             ov_reg, ov_next;

    always_comb
    begin
        state_next = state_reg;
        ph_next    = ph_reg;
        j_next     = j_reg;
        k_next     = k_reg;
        ov_next    = ov_reg;
        if (ov_reg && out_ready)
            ov_next = 1'b0;

        cmd       = '0;
        cmd.ph    = ph_reg;
        cmd.pt    = k_reg;
        cmd.tgt   = j_reg;
        cmd.act   = ACT_NONE;
        cmd.mode  = MODE_MUL;
        cmd.opsel = OPS_SQX;

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.act    = ACT_LOAD;
                    ph_next    = PH_LINE;
                    j_next     = TGT_FIRST;
                    k_next     = '0;
                    state_next = S_SQX;
                end
            end
            S_SQX:
            begin
                cmd.start = go_reg;
                if (st.unit_done)
                    state_next = S_SQY;
            end
            S_SQY:
            begin
                cmd.start = go_reg;
                cmd.opsel = OPS_SQY;
                if (st.unit_done)
                    state_next = S_RT;
            end
            S_RT:
            begin
                cmd.start = go_reg;
                cmd.mode  = MODE_SQRT;
                cmd.opsel = OPS_ROOT;
                if (st.unit_done)
                begin
                    unique case (ph_reg)
                        PH_LINE, PH_CIRC:
                        begin
                            cmd.act = (ph_reg == PH_LINE) ? ACT_ACCL : ACT_ACCC;
                            if (k_reg == 2'd2)
                                state_next = S_CMP;
                            else
                            begin
                                k_next     = k_reg + 1'b1;
                                state_next = S_SQX;
                            end
                        end
                        PH_SEG:
                        begin
                            // circle is tried only for a segment shorter than the radius
                            k_next = '0;
                            if (st.root_lt_r)
                            begin
                                ph_next    = PH_CIRC;
                                j_next     = TGT_CIRCLE;
                                state_next = S_SQX;
                            end
                            else
                                state_next = S_PROJ;
                        end
                        PH_CPN:
                        begin
                            if (st.root_zero)
                            begin
                                cmd.act = ACT_PCZERO;
                                if (k_reg == 2'd2)
                                begin
                                    ph_next    = PH_LEN;
                                    state_next = S_SQX;
                                end
                                else
                                begin
                                    k_next     = k_reg + 1'b1;
                                    state_next = S_PROJ;
                                end
                            end
                            else
                            begin
                                cmd.act    = ACT_NSAVE;
                                state_next = S_CMX;
                            end
                        end
                        PH_LEN:
                        begin
                            cmd.act    = ACT_LEN;
                            state_next = S_OUT;
                        end
                        default:
                            state_next = S_IDLE;
                    endcase
                end
            end
            S_CMP:
            begin
                cmd.act = ACT_CMP;
                k_next  = '0;
                if (ph_reg == PH_LINE)
                begin
                    if (j_reg == LAST_LINE)
                        ph_next = PH_SEG;
                    else
                        j_next = j_reg + 1'b1;
                    state_next = S_SQX;
                end
                else
                    state_next = S_PROJ;
            end
            S_PROJ:
            begin
                if (st.tgt_circ)
                begin
                    ph_next    = PH_CPN;
                    state_next = S_SQX;
                end
                else
                begin
                    cmd.act = ACT_PLINE;
                    if (k_reg == 2'd2)
                    begin
                        ph_next    = PH_LEN;
                        state_next = S_SQX;
                    end
                    else
                        k_next = k_reg + 1'b1;
                end
            end
            S_CMX, S_CMY:
            begin
                cmd.start = go_reg;
                cmd.opsel = (state_reg == S_CMX) ? OPS_CMUL_X : OPS_CMUL_Y;
                if (st.unit_done)
                    state_next = (state_reg == S_CMX) ? S_CDX : S_CDY;
            end
            S_CDX:
            begin
                cmd.start = go_reg;
                cmd.mode  = MODE_DIV;
                cmd.opsel = OPS_CDIV;
                if (st.unit_done)
                begin
                    cmd.act    = ACT_PCX;
                    state_next = S_CMY;
                end
            end
            S_CDY:
            begin
                cmd.start = go_reg;
                cmd.mode  = MODE_DIV;
                cmd.opsel = OPS_CDIV;
                if (st.unit_done)
                begin
                    cmd.act = ACT_PCY;
                    if (k_reg == 2'd2)
                    begin
                        ph_next    = PH_LEN;
                        state_next = S_SQX;
                    end
                    else
                    begin
                        k_next     = k_reg + 1'b1;
                        state_next = S_PROJ;
                    end
                end
            end
            S_OUT:
            begin
                if (!ov_reg || out_ready)
                begin
                    cmd.act    = ACT_PUBLISH;
                    ov_next    = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
                state_next = S_IDLE;
        endcase

        // unit start goes out in the first cycle of each state
        go_next = (state_next != state_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            go_reg    <= 1'b0;
            ph_reg    <= PH_LINE;
            j_reg     <= TGT_FIRST;
            k_reg     <= '0;
            ov_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            go_reg    <= go_next;
            ph_reg    <= ph_next;
            j_reg     <= j_next;
            k_reg     <= k_next;
            ov_reg    <= ov_next;
        end
    end

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = ov_reg;

endmodule

FILE: rtl/field_line_matcher.sv
// channel   direction  handshake              payload
// in        input      in_valid / in_ready    seg_start_x/y, seg_end_x/y, frame_start
// out       output     out_valid / out_ready  matched_target .. distinct_count
// cfg       input      cfg_valid / cfg_ready  cfg_index, cfg_data
//
// one shared bit-serial unit does every multiply, square root and divide;
// an item takes 35 distance passes, each a square of dx, a square of dy
// and a square root; operands are OPW = 2*DW+2 bits, DW = max(COORD_WIDTH+1,18)+1;
// trying the circle adds 3 passes and a compare, a circle match adds
// 3 passes and a multiply and a divide per axis for each point off the centre
// reset clears the controller, length sum and target set, and reloads configuration
// a new item is taken as soon as the previous one is in the output register;
// a stalled output only holds the next item at its final transfer
module field_line_matcher #(
    parameter int COORD_WIDTH = flm_pkg::COORD_WIDTH_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  logic signed [COORD_WIDTH-1:0]     seg_start_x,
    input  logic signed [COORD_WIDTH-1:0]     seg_start_y,
    input  logic signed [COORD_WIDTH-1:0]     seg_end_x,
    input  logic signed [COORD_WIDTH-1:0]     seg_end_y,
    input  logic                              frame_start,
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic [flm_pkg::TGT_W-1:0]         matched_target,
    output logic [flm_pkg::MEAN_W-1:0]        mean_distance,
    output logic signed [COORD_WIDTH-1:0]     mid_proj_x,
    output logic signed [COORD_WIDTH-1:0]     mid_proj_y,
    output logic signed [COORD_WIDTH-1:0]     start_proj_x,
    output logic signed [COORD_WIDTH-1:0]     start_proj_y,
    output logic signed [COORD_WIDTH-1:0]     end_proj_x,
    output logic signed [COORD_WIDTH-1:0]     end_proj_y,
    output logic [flm_pkg::LEN_W-1:0]         length_total,
    output logic [flm_pkg::CNT_W-1:0]         distinct_count,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [flm_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [flm_pkg::CFG_W-1:0]         cfg_data
);
    import flm_pkg::*;

    cmd_t    cmd;
    status_t st;

    assign cfg_ready = 1'b1;

    flm_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .st        (st),
        .cmd       (cmd)
    );

    flm_datapath #(
        .COORD_WIDTH (COORD_WIDTH)
    ) u_datapath (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_we         (cfg_valid & cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .seg_start_x    (seg_start_x),
        .seg_start_y    (seg_start_y),
        .seg_end_x      (seg_end_x),
        .seg_end_y      (seg_end_y),
        .frame_start    (frame_start),
        .cmd            (cmd),
        .st             (st),
        .matched_target (matched_target),
        .mean_distance  (mean_distance),
        .mid_proj_x     (mid_proj_x),
        .mid_proj_y     (mid_proj_y),
        .start_proj_x   (start_proj_x),
        .start_proj_y   (start_proj_y),
        .end_proj_x     (end_proj_x),
        .end_proj_y     (end_proj_y),
        .length_total   (length_total),
        .distinct_count (distinct_count)
    );

endmodule

FILE: tb/flm_checker.sv
`timescale 1ns / 100ps

module flm_checker (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    input  logic                            in_ready,
    input  logic signed [15:0]              seg_start_x,
    input  logic signed [15:0]              seg_start_y,
    input  logic signed [15:0]              seg_end_x,
    input  logic signed [15:0]              seg_end_y,
    input  logic                            frame_start,
    input  logic                            out_valid,
    input  logic                            out_ready,
    input  logic [flm_pkg::TGT_W-1:0]       matched_target,
    input  logic [flm_pkg::MEAN_W-1:0]      mean_distance,
    input  logic signed [15:0]              mid_proj_x,
    input  logic signed [15:0]              mid_proj_y,
    input  logic signed [15:0]              start_proj_x,
    input  logic signed [15:0]              start_proj_y,
    input  logic signed [15:0]              end_proj_x,
    input  logic signed [15:0]              end_proj_y,
    input  logic [flm_pkg::LEN_W-1:0]       length_total,
    input  logic [flm_pkg::CNT_W-1:0]       distinct_count,
    input  logic                            cfg_valid,
    input  logic                            cfg_ready,
    input  logic [flm_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [flm_pkg::CFG_W-1:0]       cfg_data,
    output int                              errors,
    output int                              pending
);
    import flm_pkg::*;

    typedef struct {
        logic [TGT_W-1:0]  tgt;
        logic [MEAN_W-1:0] mean;
        logic [15:0]       pt[6];
        logic [LEN_W-1:0]  total;
        logic [CNT_W-1:0]  cnt;
    } seg_match_t;

    logic [CFG_W-1:0] field_len, field_wid, goal_dep, goal_wid, circ_dia;
    logic [LEN_W-1:0] len_sum;
    logic [NUM_TGT-1:0] seen;
    seg_match_t match_q[$];
    logic [15:0] got_pt[6];

    function automatic longint unsigned root64(longint unsigned v);
        longint unsigned res, bitv;
        res = 0;
        bitv = 64'd1 << 62;
        while (bitv > v) bitv = bitv >> 2;
        while (bitv != 0)
        begin
            if (v >= res + bitv)
            begin
                v = v - (res + bitv);
                res = (res >> 1) + bitv;
            end
            else
                res = res >> 1;
            bitv = bitv >> 2;
        end
        return res;
    endfunction

    function automatic longint unsigned sq_dist(longint ax, longint ay, longint bx, longint by);
        longint unsigned dx, dy;
        dx = (ax > bx) ? ax - bx : bx - ax;
        dy = (ay > by) ? ay - by : by - ay;
        return dx * dx + dy * dy;
    endfunction

    function automatic longint clip(longint v, longint a, longint b);
        longint lo, hi;
        lo = (a < b) ? a : b;
        hi = (a < b) ? b : a;
        return (v < lo) ? lo : ((v > hi) ? hi : v);
    endfunction

    // half units back to 1/1024 m, rounding half up
    function automatic logic [15:0] to_out(longint v);
        longint t;
        t = v + 1;
        if (t >= 0)
            return 16'(t / 2);
        return 16'(-((-t + 1) / 2));
    endfunction

    function automatic longint circ_coord(longint p, longint unsigned n, longint r);
        longint unsigned num;
        longint q;
        num = ((p < 0) ? -p : p) * r * 2 + n;
        q = num / (2 * n);
        return (p < 0) ? -q : q;
    endfunction

    function automatic seg_match_t predict_match(longint sx, longint sy, longint ex, longint ey,
                                                 bit fs);
        longint a, b, e2, f, r, cx, cy;
        longint px[3], py[3], qx[3], qy[3];
        longint box[11][4];
        longint unsigned best, acc, n, mean, seg_len;
        int tgt;
        seg_match_t m;
        a = field_len;
        b = field_wid;
        e2 = 2 * longint'(goal_dep);
        f = goal_wid;
        r = circ_dia;
        box[0] = '{-a, -b, a, -b};
        box[1] = '{-a, b, a, b};
        box[2] = '{-a, -f, -a + e2, -f};
        box[3] = '{-a, f, -a + e2, f};
        box[4] = '{a - e2, -f, a, -f};
        box[5] = '{a - e2, f, a, f};
        box[6] = '{-a, -b, -a, b};
        box[7] = '{0, -b, 0, b};
        box[8] = '{a, -b, a, b};
        box[9] = '{-a + e2, -f, -a + e2, f};
        box[10] = '{a - e2, -f, a - e2, f};
        if (fs)
        begin
            len_sum = 0;
            seen = 0;
        end
        // half units: midpoint, start, end
        px[0] = sx + ex;
        py[0] = sy + ey;
        px[1] = 2 * sx;
        py[1] = 2 * sy;
        px[2] = 2 * ex;
        py[2] = 2 * ey;
        best = 0;
        tgt = 0;
        for (int j = 0; j < 11; j++)
        begin
            acc = 0;
            for (int k = 0; k < 3; k++)
            begin
                cx = clip(px[k], box[j][0], box[j][2]);
                cy = clip(py[k], box[j][1], box[j][3]);
                acc += root64(sq_dist(px[k], py[k], cx, cy));
            end
            if (j == 0 || acc < best)
            begin
                best = acc;
                tgt = j;
            end
        end
        if (sq_dist(px[1], py[1], px[2], py[2]) < longint'(r * r))
        begin
            acc = 0;
            for (int k = 0; k < 3; k++)
            begin
                n = root64(sq_dist(px[k], py[k], 0, 0));
                acc += (longint'(n) > r) ? n - r : r - n;
            end
            if (acc < best)
            begin
                best = acc;
                tgt = TGT_CIRCLE;
            end
        end
        for (int k = 0; k < 3; k++)
        begin
            if (tgt == TGT_CIRCLE)
            begin
                n = root64(sq_dist(px[k], py[k], 0, 0));
                if (n == 0)
                begin
                    qx[k] = r;
                    qy[k] = 0;
                end
                else
                begin
                    qx[k] = circ_coord(px[k], n, r);
                    qy[k] = circ_coord(py[k], n, r);
                end
            end
            else
            begin
                qx[k] = clip(px[k], box[tgt][0], box[tgt][2]);
                qy[k] = clip(py[k], box[tgt][1], box[tgt][3]);
            end
        end
        seg_len = (root64(sq_dist(qx[1], qy[1], qx[2], qy[2])) + 1) / 2;
        if (seg_len > 64'(32'hFFFF_FFFF - len_sum))
            len_sum = '1;
        else
            len_sum = len_sum + seg_len[31:0];
        seen = seen | NUM_TGT'(1 << tgt);
        mean = (best + MEAN_ROUND) / MEAN_DIV;
        if (mean > 65535)
            mean = 65535;
        m.tgt = TGT_W'(tgt);
        m.mean = mean[15:0];
        for (int k = 0; k < 3; k++)
        begin
            m.pt[2 * k] = to_out(qx[k]);
            m.pt[2 * k + 1] = to_out(qy[k]);
        end
        m.total = len_sum;
        m.cnt = CNT_W'($countones(seen));
        return m;
    endfunction

    function automatic int field_bad(string nm, longint unsigned want, longint unsigned got);
        if (want == got)
            return 0;
        $error("%s: expected %0h, got %0h", nm, want, got);
        return 1;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        seg_match_t m;
        if (!rst_n)
        begin
            field_len = RST_FIELD_LEN;
            field_wid = RST_FIELD_WID;
            goal_dep = RST_GOAL_DEP;
            goal_wid = RST_GOAL_WID;
            circ_dia = RST_CIRC_DIA;
            len_sum = 0;
            seen = 0;
            match_q.delete();
            errors = 0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    CFG_FIELD_LEN: field_len = cfg_data;
                    CFG_FIELD_WID: field_wid = cfg_data;
                    CFG_GOAL_DEP:  goal_dep = cfg_data;
                    CFG_GOAL_WID:  goal_wid = cfg_data;
                    CFG_CIRC_DIA:  circ_dia = cfg_data;
                    default: ;
                endcase
            end
            if (in_valid && in_ready)
                match_q.insert(match_q.size(),
                               predict_match(seg_start_x, seg_start_y, seg_end_x, seg_end_y,
                                             frame_start));
            if (out_valid && out_ready)
            begin
                if (match_q.size() == 0)
                begin
                    $error("result transfer with no segment outstanding");
                    errors++;
                end
                else
                begin
                    m = match_q.pop_front();
                    got_pt = '{mid_proj_x, mid_proj_y, start_proj_x, start_proj_y,
                               end_proj_x, end_proj_y};
                    errors += field_bad("matched_target", m.tgt, matched_target);
                    errors += field_bad("mean_distance", m.mean, mean_distance);
                    errors += field_bad("mid_proj_x", m.pt[0], got_pt[0]);
                    errors += field_bad("mid_proj_y", m.pt[1], got_pt[1]);
                    errors += field_bad("start_proj_x", m.pt[2], got_pt[2]);
                    errors += field_bad("start_proj_y", m.pt[3], got_pt[3]);
                    errors += field_bad("end_proj_x", m.pt[4], got_pt[4]);
                    errors += field_bad("end_proj_y", m.pt[5], got_pt[5]);
                    errors += field_bad("length_total", m.total, length_total);
                    errors += field_bad("distinct_count", m.cnt, distinct_count);
                end
            end
        end
        pending = match_q.size();
    end

endmodule

FILE: tb/testbench.sv
`timescale 1ns / 100ps

module testbench;
    import flm_pkg::*;

    localparam int QUIET_LIMIT = 40000;
    localparam int HOLD_CYCLES = 8000;
    localparam int PER_MODE    = 65;

    logic clk = 0;
    logic rst_n;
    logic in_valid, in_ready, frame_start;
    logic signed [15:0] seg_start_x, seg_start_y, seg_end_x, seg_end_y;
    logic out_valid, out_ready;
    logic [TGT_W-1:0] matched_target;
    logic [MEAN_W-1:0] mean_distance;
    logic signed [15:0] mid_proj_x, mid_proj_y, start_proj_x, start_proj_y;
    logic signed [15:0] end_proj_x, end_proj_y;
    logic [LEN_W-1:0] length_total;
    logic [CNT_W-1:0] distinct_count;
    logic cfg_valid, cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CFG_W-1:0] cfg_data;
    int errors, pending;
    int idle_pct = 0;
    int stall_pct = 0;
    bit hold_req = 0;
    int quiet = 0;
    int cfg_now[5];

    always #2 clk = ~clk;

    field_line_matcher #(.COORD_WIDTH(16)) u_dut (.*);

    flm_checker u_checker (.*);

    // receiver side, with one long hold-off during the first random mode
    always @(posedge clk or negedge rst_n)
    begin
        int hold_left;
        if (!rst_n)
        begin
            out_ready <= 0;
            hold_left = 0;
        end
        else
        begin
            if (hold_req)
            begin
                hold_left = HOLD_CYCLES;
                hold_req = 0;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                out_ready <= 0;
            end
            else
                out_ready <= ($urandom_range(99) >= stall_pct);
        end
    end

    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
            quiet = 0;
        else
            quiet++;
        if (quiet == QUIET_LIMIT)
        begin
            $display("testbench: done, errors");
            $finish;
        end
    end

    function automatic int fit16(int v);
        return (v > 32767) ? 32767 : ((v < -32768) ? -32768 : v);
    endfunction

    function automatic int jitter(int span);
        return $urandom_range(2 * span) - span;
    endfunction

    task automatic send_seg(int sx, int sy, int ex, int ey, bit fs);
        while ($urandom_range(99) < idle_pct)
        begin
            in_valid <= 0;
            @(posedge clk);
        end
        in_valid <= 1;
        seg_start_x <= 16'(fit16(sx));
        seg_start_y <= 16'(fit16(sy));
        seg_end_x <= 16'(fit16(ex));
        seg_end_y <= 16'(fit16(ey));
        frame_start <= fs;
        do @(posedge clk); while (!in_ready);
    endtask

    task automatic drain();
        in_valid <= 0;
        @(posedge clk);
        wait (pending == 0);
        @(posedge clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, int val);
        cfg_valid <= 1;
        cfg_index <= idx;
        cfg_data <= CFG_W'(val);
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 0;
        if (idx <= CFG_CIRC_DIA)
            cfg_now[idx] = val;
    endtask

    task automatic set_dims(int a, int b, int e, int f, int h);
        write_reg(CFG_FIELD_LEN, a);
        write_reg(CFG_FIELD_WID, b);
        write_reg(CFG_GOAL_DEP, e);
        write_reg(CFG_GOAL_WID, f);
        write_reg(CFG_CIRC_DIA, h);
    endtask

    // mostly segments lying along model lines or around the circle, some noise
    task automatic random_seg();
        int ha, hb, hf, xg, kind, c, u, v, rad, sx, sy;
        ha = cfg_now[0] / 2;
        hb = cfg_now[1] / 2;
        hf = cfg_now[3] / 2;
        xg = ha - cfg_now[2];
        kind = $urandom_range(9);
        if (kind < 3)
        begin
            case ($urandom_range(3))
                0: c = hb;
                1: c = -hb;
                2: c = hf;
                default: c = -hf;
            endcase
            u = $urandom_range(2 * ha) - ha;
            v = $urandom_range(2 * ha) - ha;
            send_seg(u, c + jitter(300), v, c + jitter(300), $urandom_range(19) == 0);
        end
        else if (kind < 6)
        begin
            case ($urandom_range(4))
                0: c = ha;
                1: c = -ha;
                2: c = 0;
                3: c = xg;
                default: c = -xg;
            endcase
            u = $urandom_range(2 * hb) - hb;
            v = $urandom_range(2 * hb) - hb;
            send_seg(c + jitter(300), u, c + jitter(300), v, $urandom_range(19) == 0);
        end
        else if (kind < 8)
        begin
            rad = cfg_now[4] / 2;
            sx = $urandom_range(2 * rad) - rad;
            sy = ($urandom_range(1) ? 1 : -1) * (rad - (sx < 0 ? -sx : sx)) + jitter(100);
            send_seg(sx, sy, sx + jitter(rad / 4 + 1), sy + jitter(rad / 4 + 1),
                     $urandom_range(19) == 0);
        end
        else
            send_seg(int'($urandom_range(65535)) - 32768, int'($urandom_range(65535)) - 32768,
                     int'($urandom_range(65535)) - 32768, int'($urandom_range(65535)) - 32768,
                     $urandom_range(19) == 0);
    endtask

    initial
    begin
        rst_n = 0;
        in_valid = 0;
        frame_start = 0;
        seg_start_x = 0;
        seg_start_y = 0;
        seg_end_x = 0;
        seg_end_y = 0;
        cfg_valid = 0;
        cfg_index = 0;
        cfg_data = 0;
        cfg_now = '{9216, 6144, 1024, 5120, 1536};
        repeat (2) @(posedge clk);
        rst_n <= 1;
        @(posedge clk);

        // directed: defaults, extremes, circle centre, frame clears
        send_seg(0, 0, 0, 0, 1);
        send_seg(-32768, -32768, 32767, 32767, 0);
        send_seg(32767, -32768, -32768, 32767, 0);
        send_seg(-32768, 32767, -32768, 32767, 0);
        send_seg(32767, 32767, 32767, 32767, 0);
        send_seg(-4608, -3072, 4608, -3072, 1);
        send_seg(-4608, 3072, 4608, 3072, 0);
        send_seg(0, -3072, 0, 3072, 0);
        send_seg(-4608, -2560, -3584, -2560, 0);
        send_seg(3584, -2560, 3584, 2560, 0);
        send_seg(768, 0, 700, 100, 0);
        send_seg(-500, 500, -560, 520, 0);
        send_seg(10, -5, -10, 5, 1);
        send_seg(1, 1, 1, 1, 0);
        send_seg(-1, -1, -1, -1, 0);
        drain();

        for (int ph = 0; ph < 6; ph++)
        begin
            case (ph)
                0: set_dims(RST_FIELD_LEN, RST_FIELD_WID, RST_GOAL_DEP, RST_GOAL_WID, RST_CIRC_DIA);
                1: set_dims(32767, 32767, 32767, 32767, 32767);
                2: set_dims(0, 0, 0, 0, 0);
                3:
                begin
                    write_reg(3'd5, 1234);
                    write_reg(3'd6, 32767);
                    write_reg(3'd7, 0);
                    set_dims($urandom_range(32767), $urandom_range(32767), $urandom_range(32767),
                             $urandom_range(32767), $urandom_range(32767));
                end
                4: set_dims(4000, 3000, 500, 2000, 3000);
                default: set_dims($urandom_range(12000), $urandom_range(9000),
                                  $urandom_range(2000), $urandom_range(6000),
                                  $urandom_range(4000));
            endcase
            for (int md = 0; md < 4; md++)
            begin
                idle_pct = (md == 1) ? 53 : ((md == 3) ? 31 : 0);
                stall_pct = (md == 2) ? 53 : ((md == 3) ? 31 : 0);
                if (ph == 0 && md == 0)
                    hold_req = 1;
                for (int i = 0; i < PER_MODE; i++)
                begin
                    random_seg();
                    // pause until the block has handed back everything
                    if (ph == 1 && md == 0 && i == 30)
                    begin
                        in_valid <= 0;
                        @(posedge clk);
                        wait (pending == 0);
                    end
                end
            end
            drain();
        end

        in_valid <= 0;
        @(posedge clk);
        wait (pending == 0);
        repeat (3000) @(posedge clk);
        if (errors == 0)
            $display("testbench: done, clean");
        else
            $display("testbench: done, errors");
        $finish;
    end

endmodule
